// ----- rtl/core/ast_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the assembly source tokenizer.
// Token kinds, character codes, limits and the record type passed from front to back.
// No dependencies.
package ast_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] STRING_KEEP_MAX = 8'd255;
	localparam logic [7:0] IDENT_KEEP_MAX  = 8'd63;

	localparam logic [62:0] VALUE_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [3:0] K_END        = 4'd0;
	localparam logic [3:0] K_COLON      = 4'd1;
	localparam logic [3:0] K_LBRACKET   = 4'd2;
	localparam logic [3:0] K_RBRACKET   = 4'd3;
	localparam logic [3:0] K_COMMA      = 4'd4;
	localparam logic [3:0] K_NEWLINE    = 4'd5;
	localparam logic [3:0] K_IDENT_END  = 4'd6;
	localparam logic [3:0] K_STRING_END = 4'd7;
	localparam logic [3:0] K_NUMBER     = 4'd8;
	localparam logic [3:0] K_UNKNOWN    = 4'd9;
	localparam logic [3:0] K_TEXT       = 4'd10;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_APOS    = 8'h27;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_Z    = 8'h5A;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;

	// One to two tokens caused by one source character.
	typedef struct packed {
		logic [1:0]  cnt;
		logic [3:0]  kind0;
		logic [3:0]  kind1;
		logic [62:0] value;
		logic [7:0]  ch;
	} ast_rec_t;

endpackage

// ----- rtl/core/ast_front.sv -----
`timescale 1ns / 1ps
// Front end of the tokenizer: lexer state and classification of each character.
// Produces at most one record, of up to two tokens, per character. Uses ast_pkg.
module ast_front import ast_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  logic [7:0] character,
	output logic     push,
	output ast_rec_t rec
);

	localparam logic [2:0] MODE_IDLE      = 3'd0;
	localparam logic [2:0] MODE_IDENT     = 3'd1;
	localparam logic [2:0] MODE_STRING    = 3'd2;
	localparam logic [2:0] MODE_NUMBER    = 3'd3;
	localparam logic [2:0] MODE_LIT_OPEN  = 3'd4;
	localparam logic [2:0] MODE_LIT_TAKEN = 3'd5;

	logic [2:0]  mode_q, mode_d;
	logic [62:0] acc_q, acc_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  lit_q, lit_d;

	logic        is_letter, is_digit, is_ident;
	logic        id_has;
	logic [3:0]  id_kind;
	logic [2:0]  id_mode;
	logic        use_idle;
	logic [66:0] acc_next;

	assign is_letter = (character >= CH_LOW_A && character <= CH_LOW_Z)
		|| (character >= CH_UP_A && character <= CH_UP_Z);
	assign is_digit  = character >= CH_ZERO && character <= CH_NINE;
	assign is_ident  = is_letter || is_digit || character == CH_UNDER || character == CH_DOT;

	assign acc_next = {acc_q, 4'b0000} - {acc_q, 4'b0000} + {1'b0, acc_q, 3'b000}
		+ {3'b000, acc_q, 1'b0} + {59'd0, character - CH_ZERO};

	always_comb begin
		id_has  = 1'b1;
		id_kind = K_UNKNOWN;
		id_mode = MODE_IDLE;
		if (character == CH_NUL) begin
			id_kind = K_END;
		end else if (character == CH_SPACE || character == CH_TAB || character == CH_CR) begin
			id_has = 1'b0;
		end else if (character == CH_COLON) begin
			id_kind = K_COLON;
		end else if (character == CH_LBRACK) begin
			id_kind = K_LBRACKET;
		end else if (character == CH_RBRACK) begin
			id_kind = K_RBRACKET;
		end else if (character == CH_COMMA) begin
			id_kind = K_COMMA;
		end else if (character == CH_LF) begin
			id_kind = K_NEWLINE;
		end else if (is_letter || character == CH_UNDER || character == CH_DOT) begin
			id_kind = K_TEXT;
			id_mode = MODE_IDENT;
		end else if (character == CH_DQUOTE) begin
			id_has  = 1'b0;
			id_mode = MODE_STRING;
		end else if (is_digit) begin
			id_has  = 1'b0;
			id_mode = MODE_NUMBER;
		end else if (character == CH_APOS) begin
			id_has  = 1'b0;
			id_mode = MODE_LIT_OPEN;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		len_d    = len_q;
		lit_d    = lit_q;
		rec      = '0;
		use_idle = 1'b0;
		case (mode_q)
			MODE_IDENT: begin
				if (is_ident) begin
					if (len_q < IDENT_KEEP_MAX) begin
						len_d     = len_q + 8'd1;
						rec.cnt   = 2'd1;
						rec.kind0 = K_TEXT;
						rec.ch    = character;
					end
				end else begin
					rec.cnt   = 2'd1;
					rec.kind0 = K_IDENT_END;
					use_idle  = 1'b1;
				end
			end
			MODE_STRING: begin
				if (character == CH_NUL) begin
					rec.cnt   = 2'd2;
					rec.kind0 = K_STRING_END;
					rec.kind1 = K_END;
					mode_d    = MODE_IDLE;
				end else if (character == CH_DQUOTE) begin
					rec.cnt   = 2'd1;
					rec.kind0 = K_STRING_END;
					mode_d    = MODE_IDLE;
				end else if (len_q < STRING_KEEP_MAX) begin
					len_d     = len_q + 8'd1;
					rec.cnt   = 2'd1;
					rec.kind0 = K_TEXT;
					rec.ch    = character;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					if (acc_next > {4'b0000, VALUE_MAX}) begin
						acc_d = VALUE_MAX;
					end else begin
						acc_d = acc_next[62:0];
					end
				end else begin
					rec.cnt   = 2'd1;
					rec.kind0 = K_NUMBER;
					rec.value = acc_q;
					use_idle  = 1'b1;
				end
			end
			MODE_LIT_OPEN: begin
				if (character == CH_NUL) begin
					rec.cnt   = 2'd2;
					rec.kind0 = K_NUMBER;
					rec.kind1 = K_END;
					mode_d    = MODE_IDLE;
				end else begin
					lit_d  = character;
					mode_d = MODE_LIT_TAKEN;
				end
			end
			MODE_LIT_TAKEN: begin
				rec.cnt   = 2'd1;
				rec.kind0 = K_NUMBER;
				rec.value = {55'd0, lit_q};
				if (character == CH_APOS) begin
					mode_d = MODE_IDLE;
				end else begin
					use_idle = 1'b1;
				end
			end
			default: begin
				use_idle = 1'b1;
			end
		endcase
		if (use_idle) begin
			mode_d = id_mode;
			if (id_mode == MODE_IDENT) begin
				len_d = 8'd1;
			end else if (id_mode == MODE_STRING) begin
				len_d = 8'd0;
			end else if (id_mode == MODE_NUMBER) begin
				acc_d = {55'd0, character - CH_ZERO};
			end
			if (id_has) begin
				if (rec.cnt == 2'd0) begin
					rec.cnt   = 2'd1;
					rec.kind0 = id_kind;
				end else begin
					rec.cnt   = 2'd2;
					rec.kind1 = id_kind;
				end
				if (id_kind == K_TEXT) begin
					rec.ch = character;
				end
			end
		end
	end

	assign push = take && rec.cnt != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			len_q  <= '0;
			lit_q  <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			len_q  <= len_d;
			lit_q  <= lit_d;
		end
	end

	a_pair_not_text_first: assert property (@(posedge clk) disable iff (!arst_n)
		push && rec.cnt == 2'd2 |-> rec.kind0 != K_TEXT)
		else $error("two-token record starts with a text character");

	a_string_nul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && mode_q == MODE_STRING && character == CH_NUL |=> mode_q == MODE_IDLE)
		else $error("end of source inside a string did not return to idle");

endmodule

// ----- rtl/core/ast_queue.sv -----
`timescale 1ns / 1ps
// Short record queue between the tokenizer front and back ends.
// Register based, one push and one pop per cycle. Uses ast_pkg.
module ast_queue import ast_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ast_rec_t push_rec,
	input  logic     pop,
	output logic     head_valid,
	output ast_rec_t head,
	output logic     full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ast_rec_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_valid = count_q != '0;
	assign full       = count_q == CW'(DEPTH);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("record pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("record popped from an empty queue");

endmodule

// ----- rtl/core/ast_back.sv -----
`timescale 1ns / 1ps
// Back end of the tokenizer: expands queued records into single tokens.
// Holds the output register. Uses ast_pkg.
module ast_back import ast_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  ast_rec_t    head,
	output logic        pop,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [3:0]  token_kind,
	output logic [62:0] number_value,
	output logic [7:0]  text_char,
	output logic        last_of_run
);

	logic        phase_q;
	logic        out_valid_q;
	logic [3:0]  kind_q;
	logic [62:0] value_q;
	logic [7:0]  char_q;
	logic        last_q;

	logic        load;
	logic [3:0]  kind;
	logic        last;

	assign load = head_valid && (!out_valid_q || !tok_stall);
	assign kind = phase_q ? head.kind1 : head.kind0;
	assign last = phase_q || head.cnt == 2'd1;
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q     <= !last;
				out_valid_q <= 1'b1;
			end else if (!tok_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind;
			value_q <= (kind == K_NUMBER) ? head.value : '0;
			char_q  <= (kind == K_TEXT) ? head.ch : '0;
			last_q  <= last;
		end
	end

	assign tok_valid    = out_valid_q;
	assign token_kind   = kind_q;
	assign number_value = value_q;
	assign text_char    = char_q;
	assign last_of_run  = last_q;

	a_second_token_pair: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> head_valid && head.cnt == 2'd2)
		else $error("second token pending without a two-token record");

endmodule

// ----- rtl/core/assembly_source_tokenizer.sv -----
`timescale 1ns / 1ps
// Top level of the assembly source tokenizer.
// Instantiates ast_front, ast_queue and ast_back. Uses ast_pkg.
//
// The block takes one source character per clock cycle and turns the stream into
// tokens; each character causes zero, one or two tokens, and last_of_run marks the
// final token caused by a character. The front end classifies a character in the
// cycle it is taken and places its tokens in a record queue of QUEUE_DEPTH entries;
// the back end sends one token per cycle while tok_stall is low, through an output
// register, so with nothing ahead of it a token is held in a queue entry and then in
// the output register before it is presented. Sustained input rate is one character
// per cycle, limited by the output port of one token per cycle when characters cause
// two tokens; the input stalls only while the queue is full. Numbers are accumulated
// with a multiply by ten and saturate at 2^63-1.
module assembly_source_tokenizer import ast_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  character,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [3:0]  token_kind,
	output logic [62:0] number_value,
	output logic [7:0]  text_char,
	output logic        last_of_run
);

	logic     take;
	logic     push;
	ast_rec_t push_rec;
	logic     pop;
	logic     head_valid;
	ast_rec_t head;
	logic     full;

	assign char_stall = full;
	assign take       = char_valid && !full;

	ast_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.character (character),
		.push      (push),
		.rec       (push_rec)
	);

	ast_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (full)
	);

	ast_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_kind   (token_kind),
		.number_value (number_value),
		.text_char    (text_char),
		.last_of_run  (last_of_run)
	);

endmodule
